>>> src/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants, codes and controller/datapath interface types for the
// priority thread slot scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int NUM_SLOTS_DEFAULT = 4;

    localparam int FUNC_W     = 3;
    localparam int PRIO_W     = 2;
    localparam int ADDR_W     = 48;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_YIELD  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXIT   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SETPRI = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_START  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_RUN  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_STARTED = 2'd3;

    // slot states
    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_RUNNABLE = 2'd1;
    localparam logic [1:0] SLOT_RUNNING  = 2'd2;

    localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic                take_in;
        logic                scan_clear;
        logic                scan_issue;
        logic                commit;
        logic                prio_wr;
        logic                fail;
        logic [STATUS_W-1:0] fail_code;
        logic                load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              run_ok;
        logic              started;
        logic              scan_last;
        logic              out_free;
    } stat_t;

endpackage

>>> src/pts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/pts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer for one scheduler operation: decode, slot scan, commit, readback
// and result hand-off.
// ----------------------------------------------------------------------------
module pts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  pts_pkg::stat_t stat,
    output pts_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DRAIN  = 4'd3;
    localparam logic [3:0] S_COMMIT = 4'd4;
    localparam logic [3:0] S_PRD    = 4'd5;
    localparam logic [3:0] S_PWR    = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.fail_code = pts_pkg::STATUS_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.scan_clear = 1'b1;
                unique case (stat.func)
                    pts_pkg::FUNC_CREATE:
                    begin
                        state_next = S_SCAN;
                    end
                    pts_pkg::FUNC_YIELD, pts_pkg::FUNC_EXIT:
                    begin
                        if (stat.run_ok)
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            cmd.fail      = 1'b1;
                            cmd.fail_code = pts_pkg::STATUS_NO_RUN;
                            state_next    = S_FIN;
                        end
                    end
                    pts_pkg::FUNC_SETPRI:
                    begin
                        if (stat.run_ok)
                        begin
                            state_next = S_PRD;
                        end
                        else
                        begin
                            cmd.fail      = 1'b1;
                            cmd.fail_code = pts_pkg::STATUS_NO_RUN;
                            state_next    = S_FIN;
                        end
                    end
                    pts_pkg::FUNC_START:
                    begin
                        if (stat.started)
                        begin
                            cmd.fail      = 1'b1;
                            cmd.fail_code = pts_pkg::STATUS_STARTED;
                            state_next    = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_FIN;
            end
            S_PRD:
            begin
                state_next = S_PWR;
            end
            S_PWR:
            begin
                cmd.prio_wr = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register can take the item
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/pts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_dp
// Slot table, priority and entry memories, sequential best-slot scan and the
// result register.
// ----------------------------------------------------------------------------
module pts_dp #(
    parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [pts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [pts_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  pts_pkg::cmd_t                    cmd,
    output pts_pkg::stat_t                   stat
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int PW = pts_pkg::PRIO_W;
    localparam int AW = pts_pkg::ADDR_W;

    // latched operation
    logic [pts_pkg::FUNC_W-1:0] func_reg;
    logic [PW-1:0]              prio_reg;
    logic [AW-1:0]              addr_reg;
    logic [PW-1:0]              prio_sat;

    // scheduler state
    logic [1:0]    slot_state_reg [NUM_SLOTS];
    logic [1:0]    slot_state_next [NUM_SLOTS];
    logic [SW-1:0] run_reg;
    logic [SW-1:0] run_next;
    logic          started_reg;
    logic          started_next;

    // scan
    logic [SW-1:0] idx_reg;
    logic          cand_v_reg;
    logic          cand_hit_reg;
    logic [SW-1:0] cand_idx_reg;
    logic          best_v_reg;
    logic [SW-1:0] best_idx_reg;
    logic [PW-1:0] best_prio_reg;
    logic          is_create;
    logic          cand_hit;
    logic          best_take;

    // per-item result
    logic [pts_pkg::STATUS_W-1:0] status_reg;
    logic [pts_pkg::STATUS_W-1:0] status_next;
    logic                         switched_reg;
    logic                         switched_next;
    logic [PW-1:0]                old_prio_reg;
    logic                         out_valid_reg;
    logic [pts_pkg::OUT_TDATA_W-1:0] out_data_reg;

    // memories
    logic          prio_we;
    logic [SW-1:0] prio_waddr;
    logic [SW-1:0] prio_raddr;
    logic [PW-1:0] prio_rdata;
    logic          entry_we;
    logic [AW-1:0] entry_rdata;

    logic          run_ok;
    logic [SW+1:0] slot_ext;
    logic [SW-1:0] slot_sel;
    logic [PW-1:0] cur_prio;
    logic [AW-1:0] run_addr;

    assign prio_sat  = (s_axis_tdata[PW-1:0] > pts_pkg::PRIO_HIGH) ? pts_pkg::PRIO_HIGH
                                                                  : s_axis_tdata[PW-1:0];
    assign is_create = (func_reg == pts_pkg::FUNC_CREATE);
    assign run_ok    = started_reg && (slot_state_reg[run_reg] == pts_pkg::SLOT_RUNNING);

    assign cand_hit  = is_create ? (slot_state_reg[idx_reg] == pts_pkg::SLOT_FREE)
                                 : (slot_state_reg[idx_reg] == pts_pkg::SLOT_RUNNABLE);
    // first hit wins for create, strictly higher priority wins otherwise
    assign best_take = cand_v_reg && cand_hit_reg &&
                       (!best_v_reg || (!is_create && (prio_rdata > best_prio_reg)));

    assign stat.func      = func_reg;
    assign stat.run_ok    = run_ok;
    assign stat.started   = started_reg;
    assign stat.scan_last = (idx_reg == SW'(NUM_SLOTS - 1));
    assign stat.out_free  = !out_valid_reg || m_axis_tready;

    // memory ports
    assign entry_we   = cmd.commit && is_create && best_v_reg;
    assign prio_we    = entry_we || cmd.prio_wr;
    assign prio_waddr = cmd.prio_wr ? run_reg : best_idx_reg;
    assign prio_raddr = cmd.scan_issue ? idx_reg : run_reg;

    pts_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_SLOTS)
    ) u_prio_ram (
        .clk   (clk),
        .we    (prio_we),
        .waddr (prio_waddr),
        .wdata (prio_reg),
        .raddr (prio_raddr),
        .rdata (prio_rdata)
    );

    pts_ram #(
        .WIDTH (AW),
        .DEPTH (NUM_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (best_idx_reg),
        .wdata (addr_reg),
        .raddr (run_reg),
        .rdata (entry_rdata)
    );

    // commit of the scan outcome
    always_comb
    begin
        slot_state_next = slot_state_reg;
        run_next        = run_reg;
        started_next    = started_reg;
        status_next     = status_reg;
        switched_next   = switched_reg;
        if (cmd.take_in)
        begin
            status_next   = pts_pkg::STATUS_OK;
            switched_next = 1'b0;
        end
        else if (cmd.fail)
        begin
            status_next = cmd.fail_code;
        end
        else if (cmd.commit)
        begin
            unique case (func_reg)
                pts_pkg::FUNC_CREATE:
                begin
                    if (best_v_reg)
                    begin
                        slot_state_next[best_idx_reg] = pts_pkg::SLOT_RUNNABLE;
                    end
                    else
                    begin
                        status_next = pts_pkg::STATUS_NO_FREE;
                    end
                end
                pts_pkg::FUNC_YIELD:
                begin
                    if (best_v_reg)
                    begin
                        slot_state_next[run_reg]      = pts_pkg::SLOT_RUNNABLE;
                        slot_state_next[best_idx_reg] = pts_pkg::SLOT_RUNNING;
                        run_next                      = best_idx_reg;
                        switched_next                 = 1'b1;
                    end
                end
                pts_pkg::FUNC_EXIT, pts_pkg::FUNC_START:
                begin
                    if (func_reg == pts_pkg::FUNC_EXIT)
                    begin
                        slot_state_next[run_reg] = pts_pkg::SLOT_FREE;
                    end
                    else
                    begin
                        started_next = 1'b1;
                    end
                    if (best_v_reg)
                    begin
                        slot_state_next[best_idx_reg] = pts_pkg::SLOT_RUNNING;
                        run_next                      = best_idx_reg;
                        switched_next                 = 1'b1;
                    end
                    else
                    begin
                        status_next = pts_pkg::STATUS_NO_RUN;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_state_reg[i] <= pts_pkg::SLOT_FREE;
            end
            run_reg       <= '0;
            started_reg   <= 1'b0;
            idx_reg       <= '0;
            cand_v_reg    <= 1'b0;
            best_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_state_reg <= slot_state_next;
            run_reg        <= run_next;
            started_reg    <= started_next;
            cand_v_reg     <= cmd.scan_issue;
            if (cmd.scan_clear)
            begin
                idx_reg    <= '0;
                best_v_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    idx_reg <= idx_reg + SW'(1);
                end
                if (best_take)
                begin
                    best_v_reg <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result fields of the slot now running
    assign slot_sel = is_create ? (best_v_reg ? best_idx_reg : '0)
                                : (run_ok ? run_reg : '0);
    assign slot_ext = {2'b00, slot_sel};
    assign cur_prio = run_ok ? prio_rdata : '0;
    assign run_addr = run_ok ? entry_rdata : '0;

    // payload
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        switched_reg <= switched_next;
        cand_hit_reg <= cand_hit;
        cand_idx_reg <= idx_reg;
        if (cmd.take_in)
        begin
            func_reg     <= s_axis_tuser;
            prio_reg     <= prio_sat;
            addr_reg     <= s_axis_tdata[PW +: AW];
            old_prio_reg <= '0;
        end
        if (cmd.prio_wr)
        begin
            old_prio_reg <= prio_rdata;
        end
        if (best_take && !cmd.scan_clear)
        begin
            best_idx_reg  <= cand_idx_reg;
            best_prio_reg <= prio_rdata;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {7'd0, cur_prio, old_prio_reg, run_addr, switched_reg,
                             slot_ext[1:0], status_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> src/priority_thread_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_thread_slot_scheduler
// Fixed-priority scheduler over a table of thread slots.
// ----------------------------------------------------------------------------
// Usage:
//   One request item enters on the s_axis channel (operation in tuser,
//   priority and entry address in tdata) and produces exactly one result
//   item on the m_axis channel.
//   Create, yield, exit and start scan the slot table one slot per cycle
//   through the priority memory read port, then commit. Set priority
//   reads the running slot's priority and then writes it; a request
//   that fails at once or an unused code goes straight to the final step.
//   A new item is accepted in the cycle after the previous result is
//   loaded, so the block takes no new item before it is through with
//   the last one.
//   Reset empties the table (all slots free), clears the running slot and
//   the started flag, and drops any result not yet taken.
//   The result sits in an output register; a stalled receiver holds it,
//   and the block takes and processes the next item meanwhile, then waits
//   in its final step until the register is free.
// ----------------------------------------------------------------------------
module priority_thread_slot_scheduler #(
    parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // prio_in[1:0], entry_address[49:2], zero [55:50]
    input  logic [pts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // func[2:0]
    input  logic [pts_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0], slot_index[3:2], switched[4], run_address[52:5],
    // old_priority[54:53], current_priority[56:55], zero [63:57]
    output logic [pts_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    pts_pkg::cmd_t  cmd;
    pts_pkg::stat_t stat;

    pts_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    pts_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
